>>> hw/rtl/lwac_pkg.sv
// lwac_pkg: shared types, widths and register codes of the line weighted average block
// depends on nothing; used by every module of the block by scoped names
`timescale 1ns / 1ps

package lwac_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int REG_W        = 11;
	localparam int CFG_INDEX_W  = 2;
	localparam int PIXEL_W      = 16;
	localparam int CH5_W        = 5;
	localparam int CH6_W        = 6;
	localparam int WEIGHT_W     = 11;
	localparam int RED_SUM_W    = 26;
	localparam int GREEN_SUM_W  = 27;
	localparam int BLUE_SUM_W   = 26;
	localparam int WEIGHT_SUM_W = 21;

	localparam logic [CH5_W-1:0] CH5_MAX = 5'h1F;
	localparam logic [CH6_W-1:0] CH6_MAX = 6'h3F;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	localparam cfg_index_t REG_CENTER_WEIGHT = 2'd0;
	localparam cfg_index_t REG_LINE_WIDTH    = 2'd1;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [CH5_W-1:0] avg_red;
		logic [CH6_W-1:0] avg_green;
		logic [CH5_W-1:0] avg_blue;
		logic             no_weight;
	} result_t;

	typedef struct packed {
		logic [REG_W-1:0] center_weight;
		logic [REG_W-1:0] line_width;
	} cfg_t;

	// totals of one finished line, handed from the accumulator to the divider
	typedef struct packed {
		logic [RED_SUM_W-1:0]    red_sum;
		logic [GREEN_SUM_W-1:0]  green_sum;
		logic [BLUE_SUM_W-1:0]   blue_sum;
		logic [WEIGHT_SUM_W-1:0] weight_sum;
	} line_sum_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

>>> hw/rtl/lwac_front.sv
// lwac_front: pixel intake, triangular weight and saturating channel accumulators
// depends on lwac_pkg; pushes the totals of each finished line into lwac_queue
`timescale 1ns / 1ps

module lwac_front #(
	parameter int MAX_WIDTH = lwac_pkg::MAX_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lwac_pkg::cfg_t      cfg,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  lwac_pkg::pixel_t    pix,
	output logic                push,
	output lwac_pkg::line_sum_t push_data,
	input  logic                queue_full
);

	localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CENTER_W = lwac_pkg::REG_W - 1;
	localparam int DW = (PW > CENTER_W) ? PW : CENTER_W;
	localparam int CW = (DW > lwac_pkg::REG_W) ? DW : lwac_pkg::REG_W;
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_WIDTH - 1);

	localparam int RW  = lwac_pkg::RED_SUM_W;
	localparam int GW  = lwac_pkg::GREEN_SUM_W;
	localparam int BW  = lwac_pkg::BLUE_SUM_W;
	localparam int WSW = lwac_pkg::WEIGHT_SUM_W;
	localparam int WW  = lwac_pkg::WEIGHT_W;

	logic [PW-1:0] pos_q;

	logic                      valid_s1;
	logic                      last_s1;
	logic [WW-1:0]             weight_s1;
	logic [lwac_pkg::CH5_W-1:0] red_s1;
	logic [lwac_pkg::CH6_W-1:0] green_s1;
	logic [lwac_pkg::CH5_W-1:0] blue_s1;

	logic [RW-1:0]  red_sum_q;
	logic [GW-1:0]  green_sum_q;
	logic [BW-1:0]  blue_sum_q;
	logic [WSW-1:0] weight_sum_q;

	logic [DW-1:0] pos_ext;
	logic [DW-1:0] center_ext;
	logic [DW-1:0] gap;
	logic [CW-1:0] cw_ext;
	logic [CW-1:0] gap_ext;
	logic [WW-1:0] weight;

	logic [15:0] prod_r;
	logic [16:0] prod_g;
	logic [15:0] prod_b;
	logic [RW:0]  red_add;
	logic [GW:0]  green_add;
	logic [BW:0]  blue_add;
	logic [WSW:0] weight_add;

	logic accept;
	logic advance;

	assign advance   = valid_s1 && !(last_s1 && queue_full);
	assign pix_ready = !valid_s1 || advance;
	assign accept    = pix_valid && pix_ready;

	// distance from line center, weight clamped at zero
	always_comb begin
		pos_ext    = DW'(pos_q);
		center_ext = DW'(cfg.line_width[lwac_pkg::REG_W-1:1]);
		gap        = (pos_ext >= center_ext) ? (pos_ext - center_ext) : (center_ext - pos_ext);
		cw_ext     = CW'(cfg.center_weight);
		gap_ext    = CW'(gap);
		weight     = (cw_ext > gap_ext) ? WW'(cw_ext - gap_ext) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (pix.last_pixel) begin
					pos_q <= '0;
				end else if (pos_q != POS_LAST) begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= pix.last_pixel;
			weight_s1 <= weight;
			red_s1    <= pix.pixel[15:11];
			green_s1  <= pix.pixel[10:5];
			blue_s1   <= pix.pixel[4:0];
		end
	end

	// saturating accumulate: carry out means the sum passed the all-ones limit
	always_comb begin
		prod_r     = 16'(red_s1) * 16'(weight_s1);
		prod_g     = 17'(green_s1) * 17'(weight_s1);
		prod_b     = 16'(blue_s1) * 16'(weight_s1);
		red_add    = {1'b0, red_sum_q} + (RW+1)'(prod_r);
		green_add  = {1'b0, green_sum_q} + (GW+1)'(prod_g);
		blue_add   = {1'b0, blue_sum_q} + (BW+1)'(prod_b);
		weight_add = {1'b0, weight_sum_q} + (WSW+1)'(weight_s1);

		push_data.red_sum    = red_add[RW] ? '1 : red_add[RW-1:0];
		push_data.green_sum  = green_add[GW] ? '1 : green_add[GW-1:0];
		push_data.blue_sum   = blue_add[BW] ? '1 : blue_add[BW-1:0];
		push_data.weight_sum = weight_add[WSW] ? '1 : weight_add[WSW-1:0];
	end

	assign push = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_sum_q    <= '0;
			green_sum_q  <= '0;
			blue_sum_q   <= '0;
			weight_sum_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				red_sum_q    <= '0;
				green_sum_q  <= '0;
				blue_sum_q   <= '0;
				weight_sum_q <= '0;
			end else begin
				red_sum_q    <= push_data.red_sum;
				green_sum_q  <= push_data.green_sum;
				blue_sum_q   <= push_data.blue_sum;
				weight_sum_q <= push_data.weight_sum;
			end
		end
	end

endmodule

>>> hw/rtl/lwac_queue.sv
// lwac_queue: short queue of finished line totals between accumulator and divider
// depends on lwac_pkg
`timescale 1ns / 1ps

module lwac_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lwac_pkg::line_sum_t   push_data,
	input  logic                  pop,
	output lwac_pkg::line_sum_t   head,
	output lwac_pkg::queue_stat_t stat
);

	localparam int PTR_W = lwac_pkg::QUEUE_PTR_W;
	localparam int CNT_W = lwac_pkg::QUEUE_CNT_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(lwac_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(lwac_pkg::QUEUE_DEPTH);

	lwac_pkg::line_sum_t entry_q [lwac_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/lwac_divider.sv
// lwac_divider: per-line restoring division of the three channel sums by the weight total
// depends on lwac_pkg; pops lwac_queue and holds the result register
`timescale 1ns / 1ps

module lwac_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                queue_empty,
	input  lwac_pkg::line_sum_t head,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output lwac_pkg::result_t   res
);

	localparam int DIV_W  = lwac_pkg::GREEN_SUM_W + 1;
	localparam int STEP_W = $clog2(lwac_pkg::CH6_W);
	localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(lwac_pkg::CH6_W - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_STEP  = 4'b0100,
		ST_DONE  = 4'b1000
	} div_state_t;

	div_state_t state_q;
	logic [STEP_W-1:0] step_q;

	logic [lwac_pkg::RED_SUM_W-1:0]    rem_r_q;
	logic [lwac_pkg::GREEN_SUM_W-1:0]  rem_g_q;
	logic [lwac_pkg::BLUE_SUM_W-1:0]   rem_b_q;
	logic [lwac_pkg::WEIGHT_SUM_W-1:0] ws_q;
	logic [lwac_pkg::CH5_W-1:0] quo_r_q;
	logic [lwac_pkg::CH6_W-1:0] quo_g_q;
	logic [lwac_pkg::CH5_W-1:0] quo_b_q;
	logic ovf_r_q;
	logic ovf_g_q;
	logic ovf_b_q;

	logic res_valid_q;
	lwac_pkg::result_t res_q;

	logic [DIV_W-1:0] den;
	logic [DIV_W-1:0] den5;
	logic [DIV_W-1:0] den6;
	logic [DIV_W-1:0] num_r;
	logic [DIV_W-1:0] num_g;
	logic [DIV_W-1:0] num_b;
	logic ge_r;
	logic ge_g;
	logic ge_b;
	logic out_free;

	assign out_free  = !res_valid_q || res_ready;
	assign pop       = (state_q == ST_IDLE) && !queue_empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		num_r = DIV_W'(rem_r_q);
		num_g = DIV_W'(rem_g_q);
		num_b = DIV_W'(rem_b_q);
		den   = DIV_W'(ws_q) << step_q;
		den5  = DIV_W'(ws_q) << lwac_pkg::CH5_W;
		den6  = DIV_W'(ws_q) << lwac_pkg::CH6_W;
		ge_r  = num_r >= den;
		ge_g  = num_g >= den;
		ge_b  = num_b >= den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q  <= STEP_FIRST;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_r_q <= head.red_sum;
				rem_g_q <= head.green_sum;
				rem_b_q <= head.blue_sum;
				ws_q    <= head.weight_sum;
			end
			// quotient above channel range: clamp, remaining steps then stay in range
			ST_CHECK: begin
				ovf_r_q <= num_r >= den5;
				ovf_g_q <= num_g >= den6;
				ovf_b_q <= num_b >= den5;
				quo_r_q <= '0;
				quo_g_q <= '0;
				quo_b_q <= '0;
			end
			ST_STEP: begin
				if (ge_r) begin
					rem_r_q <= lwac_pkg::RED_SUM_W'(num_r - den);
				end
				if (ge_g) begin
					rem_g_q <= lwac_pkg::GREEN_SUM_W'(num_g - den);
				end
				if (ge_b) begin
					rem_b_q <= lwac_pkg::BLUE_SUM_W'(num_b - den);
				end
				quo_r_q <= {quo_r_q[lwac_pkg::CH5_W-2:0], ge_r};
				quo_g_q <= {quo_g_q[lwac_pkg::CH6_W-2:0], ge_g};
				quo_b_q <= {quo_b_q[lwac_pkg::CH5_W-2:0], ge_b};
			end
			ST_DONE: begin
				if (out_free) begin
					if (ws_q == '0) begin
						res_q.avg_red   <= '0;
						res_q.avg_green <= '0;
						res_q.avg_blue  <= '0;
						res_q.no_weight <= 1'b1;
					end else begin
						res_q.avg_red   <= ovf_r_q ? lwac_pkg::CH5_MAX : quo_r_q;
						res_q.avg_green <= ovf_g_q ? lwac_pkg::CH6_MAX : quo_g_q;
						res_q.avg_blue  <= ovf_b_q ? lwac_pkg::CH5_MAX : quo_b_q;
						res_q.no_weight <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/line_weighted_average_color.sv
// line_weighted_average_color: top level, configuration registers and block wiring
// depends on lwac_pkg, lwac_front, lwac_queue and lwac_divider
`timescale 1ns / 1ps

// Pixels of one line enter at one per cycle; each is weighted when it is taken, held in a
// stage register and accumulated from there, and the line totals move into a two-entry
// queue when the last pixel is accumulated. A shared back end divides one line's totals
// in steps (load, range check, six restoring compare-subtract steps, result write), and
// the result write waits for a free output. The back end works while the next line
// accumulates; pixel requests stall only while a last pixel waits on a full queue, when lines
// end faster than they are divided or the result register is not taken. Configuration writes
// are taken in every cycle; indexes other than the two registers are ignored.

module line_weighted_average_color #(
	parameter int MAX_WIDTH = lwac_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  lwac_pkg::pixel_t                 pix,
	output logic                             res_valid,
	input  logic                             res_ready,
	output lwac_pkg::result_t                res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  lwac_pkg::cfg_index_t             cfg_index,
	input  logic [lwac_pkg::REG_W-1:0]       cfg_data
);

	lwac_pkg::cfg_t        cfg_q;
	logic                  push;
	lwac_pkg::line_sum_t   push_data;
	logic                  pop;
	lwac_pkg::line_sum_t   head;
	lwac_pkg::queue_stat_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_weight <= lwac_pkg::REG_W'(2);
			cfg_q.line_width    <= lwac_pkg::REG_W'(96);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lwac_pkg::REG_CENTER_WEIGHT: cfg_q.center_weight <= cfg_data;
				lwac_pkg::REG_LINE_WIDTH:    cfg_q.line_width    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lwac_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.push      (push),
		.push_data (push_data),
		.queue_full(q_stat.full)
	);

	lwac_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	lwac_divider u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_empty(q_stat.empty),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// pixel requests stall only behind a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> q_stat.full)
		else $error("pixel request stalled while line queue not full");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("line queue full and empty at once");

	a_no_weight_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.no_weight) |->
		(res.avg_red == '0 && res.avg_green == '0 && res.avg_blue == '0))
		else $error("zero weight result with nonzero averages");

endmodule
